FILE: hdl/confusion_matrix_metrics_engine_assert.svh
// Assertion macros shared by the confusion matrix engine checkers
`ifndef CONFUSION_MATRIX_METRICS_ENGINE_ASSERT_SVH
`define CONFUSION_MATRIX_METRICS_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CMME_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cmme assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define CMME_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cmme assertion failed");

`endif

FILE: hdl/cmme_pkg.sv
// Types, constants and helpers shared by the confusion matrix engine
package cmme_pkg;

  localparam int CLASSES     = 16;
  localparam int COUNT_WIDTH = 32;
  localparam int CLS_W       = $clog2(CLASSES);
  localparam int LEN_W       = CLS_W + 1;
  localparam int GRID_DEPTH  = CLASSES * CLASSES;
  localparam int GRID_AW     = 2 * CLS_W;
  localparam int SUM_W       = 64;
  localparam int HALF_W      = SUM_W / 2;
  localparam int BETA_W      = 12;
  localparam int B2_W        = 2 * BETA_W;
  localparam int K_W         = B2_W + 1;
  localparam int PROD_W      = HALF_W + K_W;
  localparam int DEN_W       = SUM_W + K_W + 1;
  localparam int RATIO_W     = 17;
  localparam int Q16_BITS    = 16;
  localparam int MSUM_W      = RATIO_W + CLS_W;
  localparam int STEP_W      = $clog2(MSUM_W + 1);

  localparam logic [RATIO_W-1:0] Q16_ONE    = RATIO_W'(1 << Q16_BITS);
  localparam logic [BETA_W-1:0]  BETA_RESET = BETA_W'(256);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_CAPACITY = 2'd2;

  localparam int ERR_CAP = 0;
  localparam int ERR_NF  = 1;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_DEL   = 4'd1,
    OP_GET   = 4'd2,
    OP_ACC   = 4'd3,
    OP_PREC  = 4'd4,
    OP_REC   = 4'd5,
    OP_FB    = 4'd6,
    OP_MPREC = 4'd7,
    OP_MREC  = 4'd8,
    OP_MFB   = 4'd9
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD,
    S_SCAN,
    S_DRAIN,
    S_CALC,
    S_MUL,
    S_MACC,
    S_FBADD,
    S_CHECK,
    S_DIV,
    S_RES
  } state_t;

  typedef struct packed {
    logic [3:0] operation;
    logic [7:0] actual_class;
    logic [7:0] predicted_class;
  } item_t;

  typedef struct packed {
    logic [31:0]        count_value;
    logic [RATIO_W-1:0] ratio_value;
    logic [1:0]         status_code;
    logic [1:0]         error_flags;
  } result_t;

  typedef struct packed {
    logic start;
    logic mean_mode;
  } div_ctl_t;

  function automatic logic is_mean(logic [3:0] op);
    return op == OP_MPREC || op == OP_MREC || op == OP_MFB;
  endfunction

  function automatic logic is_scan(logic [3:0] op);
    return op == OP_ACC || op == OP_PREC || op == OP_REC || op == OP_FB;
  endfunction

  function automatic logic [31:0] cnt_out(logic [COUNT_WIDTH-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return w[31:0];
  endfunction

endpackage

FILE: hdl/cmme_ram.sv
// Generic single-write, single-read RAM with registered read data
module cmme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/cmme_div.sv
// Restoring divider, one quotient bit per cycle, for Q1.16 ratios and means
module cmme_div (
  input  logic                            clk,
  input  logic                            rst,
  input  cmme_pkg::div_ctl_t              ctl,
  input  logic [cmme_pkg::DEN_W-1:0]      num,
  input  logic [cmme_pkg::DEN_W-1:0]      den,
  input  logic [cmme_pkg::MSUM_W-1:0]     feed,
  output logic                            done,
  output logic [cmme_pkg::MSUM_W-1:0]     quot
);
  import cmme_pkg::*;

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  dd;
  logic [MSUM_W-1:0] sh;
  logic [STEP_W-1:0] cnt;
  logic              run;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  // shift in the next dividend bit, try the subtract
  assign trial = {rem, sh[MSUM_W-1]};
  assign diff  = trial - {1'b0, dd};
  assign ge    = trial >= {1'b0, dd};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && cnt == STEP_W'(1);
      if (ctl.start) begin
        run <= 1'b1;
      end else if (run && cnt == STEP_W'(1)) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem  <= ctl.mean_mode ? '0 : num;
      sh   <= ctl.mean_mode ? feed : '0;
      dd   <= den;
      cnt  <= ctl.mean_mode ? STEP_W'(MSUM_W) : STEP_W'(Q16_BITS);
      quot <= '0;
    end else if (run) begin
      rem  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      sh   <= {sh[MSUM_W-2:0], 1'b0};
      cnt  <= cnt - STEP_W'(1);
      quot <= {quot[MSUM_W-2:0], ge};
    end
  end

endmodule

FILE: hdl/confusion_matrix_metrics_engine.sv
// Top level: confusion matrix counter grid with metric sequencer
//
// Confusion matrix engine. A 16 x 16 grid of 32-bit counters (row = true
// class, column = predicted class) lives in one RAM with a registered read;
// a valid bit per entry makes the grid read as zero after reset, so there is
// no clearing pass. Issue a word with start while busy is low. Add, del and
// get read the entry as the word is taken; add and del then write it back.
// Accuracy, precision and recall walk the tracked part of the grid one entry
// per cycle, with a step at the end of each live row, then run a 16-step
// restoring divide unless the denominator is zero or the ratio reaches one.
// F-beta first builds its numerator and denominator with 32 x 25
// multiply-accumulates and then adds the false positives. The means repeat
// the per-class metric for every live row and finish with a restoring divide
// by the row count. The result word is shown for exactly one cycle with done
// high; the receiver cannot stall it, so capture it on that cycle. Unused
// operation codes and a mean over an empty grid answer at once. Write beta
// on the cfg channel only while the block is idle; cfg_ready is always high.
module confusion_matrix_metrics_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  cmme_pkg::item_t               cmd,
  output logic                          done,
  output cmme_pkg::result_t             result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cmme_pkg::BETA_W-1:0]   cfg_data
);
  import cmme_pkg::*;

  state_t state, state_next;

  // captured command
  logic [3:0] op;
  logic [7:0] ca, cp, cls;

  // tracking state
  logic [LEN_W-1:0] live;
  logic [LEN_W-1:0] rl [CLASSES];
  logic [GRID_DEPTH-1:0] vld;
  logic [1:0] errs, errs_next;
  logic [BETA_W-1:0] beta;
  logic [B2_W-1:0] b2;

  // grid RAM port
  logic                   grid_we;
  logic [GRID_AW-1:0]     waddr, raddr;
  logic [COUNT_WIDTH-1:0] wdata, rdata;
  logic                   rd_vld;

  // scan pipeline and sums
  logic [LEN_W-1:0] sr, sp;
  logic             rv, rd_issue;
  logic [CLS_W-1:0] rr, rp;
  logic [SUM_W-1:0] s0, s1, s2, v;

  // multiply and divide datapath
  logic [DEN_W-1:0]   numr, denr;
  logic [PROD_W-1:0]  prod;
  logic [1:0]         mstep;
  logic [HALF_W-1:0]  mul_a;
  logic [K_W-1:0]     mul_k;
  logic [MSUM_W-1:0]  msum, msum_sum;
  logic [RATIO_W-1:0] qv;
  logic               mfin;
  div_ctl_t           div_ctl;
  logic               div_done;
  logic [MSUM_W-1:0]  div_quot;

  // result staging
  result_t res_next;
  logic    done_next;

  // update path decode
  logic                   a_ok, p_ok, miss, short_row;
  logic [LEN_W-1:0]       rl_a;
  logic [COUNT_WIDTH-1:0] cur;
  logic [CLS_W-1:0]       mx;

  assign busy      = state != S_IDLE;
  assign cfg_ready = 1'b1;

  cmme_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(GRID_DEPTH)) u_grid (
    .clk   (clk),
    .we    (grid_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  cmme_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctl  (div_ctl),
    .num  (numr),
    .den  (div_ctl.mean_mode ? DEN_W'(live) : denr),
    .feed (msum_sum),
    .done (div_done),
    .quot (div_quot)
  );

  // an entry never written reads as zero
  assign cur = rd_vld ? rdata : '0;
  assign v   = SUM_W'(cur);

  assign a_ok = {1'b0, ca} < 9'(CLASSES);
  assign p_ok = {1'b0, cp} < 9'(CLASSES);
  assign rl_a = a_ok ? rl[ca[CLS_W-1:0]] : '0;
  assign miss = !a_ok || {1'b0, ca} >= 9'(live) ||
                (op == OP_DEL && {1'b0, cp} >= 9'(rl_a));
  assign short_row = !p_ok || {1'b0, cp} >= 9'(rl_a);
  assign mx = (ca > cp) ? ca[CLS_W-1:0] : cp[CLS_W-1:0];

  assign waddr = {ca[CLS_W-1:0], cp[CLS_W-1:0]};
  assign wdata = (op == OP_ADD) ? cur + COUNT_WIDTH'(1) : cur - COUNT_WIDTH'(1);
  assign grid_we = state == S_UPD &&
                   ((op == OP_ADD && a_ok && p_ok) ||
                    (op == OP_DEL && !miss && !short_row));

  // command word addresses the grid on accept, the scan counters otherwise
  assign raddr = (state == S_IDLE) ?
                 {cmd.actual_class[CLS_W-1:0], cmd.predicted_class[CLS_W-1:0]} :
                 {sr[CLS_W-1:0], sp[CLS_W-1:0]};

  assign rd_issue = state == S_SCAN && sr < live && sp < rl[sr[CLS_W-1:0]];

  assign mul_a = mstep[0] ? (mstep[1] ? s1[SUM_W-1:HALF_W] : s0[SUM_W-1:HALF_W])
                          : (mstep[1] ? s1[HALF_W-1:0]     : s0[HALF_W-1:0]);
  assign mul_k = mstep[1] ? K_W'(b2) : K_W'(Q16_ONE) + K_W'(b2);

  assign msum_sum = msum + MSUM_W'(qv);

  always_comb begin
    errs_next = errs;
    if (state == S_UPD) begin
      if (op == OP_ADD && !(a_ok && p_ok)) begin
        errs_next[ERR_CAP] = 1'b1;
      end
      if ((op == OP_DEL || op == OP_GET) && miss) begin
        errs_next[ERR_NF] = 1'b1;
      end
    end
  end

  // sequencer: next state, result word, divider kick
  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    res_next   = '0;
    res_next.error_flags = errs_next;
    div_ctl    = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (cmd.operation == OP_ADD || cmd.operation == OP_DEL ||
              cmd.operation == OP_GET) begin
            state_next = S_UPD;
          end else if (is_scan(cmd.operation) ||
                       (is_mean(cmd.operation) && live != '0)) begin
            state_next = S_SCAN;
          end else begin
            done_next = 1'b1;
          end
        end
      end
      S_UPD: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        if (op == OP_ADD) begin
          if (a_ok && p_ok) begin
            res_next.count_value = cnt_out(wdata);
          end else begin
            res_next.status_code = ST_CAPACITY;
          end
        end else if (miss) begin
          res_next.status_code = ST_NOTFOUND;
          res_next.count_value = '1;
        end else if (!short_row) begin
          res_next.count_value = cnt_out((op == OP_DEL) ? wdata : cur);
        end
      end
      S_SCAN: begin
        if (sr >= live) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_CALC;
      end
      S_CALC: begin
        state_next = (op == OP_FB || op == OP_MFB) ? S_MUL : S_CHECK;
      end
      S_MUL: begin
        state_next = S_MACC;
      end
      S_MACC: begin
        state_next = (mstep == 2'd3) ? S_FBADD : S_MUL;
      end
      S_FBADD: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (denr == '0 || numr >= denr) begin
          state_next = S_RES;
        end else begin
          div_ctl.start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (mfin) begin
            done_next            = 1'b1;
            res_next.ratio_value = div_quot[RATIO_W-1:0];
            state_next           = S_IDLE;
          end else begin
            state_next = S_RES;
          end
        end
      end
      S_RES: begin
        if (!is_mean(op)) begin
          done_next            = 1'b1;
          res_next.ratio_value = qv;
          state_next           = S_IDLE;
        end else if ({1'b0, cls} + 9'd1 >= 9'(live)) begin
          div_ctl.start     = 1'b1;
          div_ctl.mean_mode = 1'b1;
          state_next        = S_DIV;
        end else begin
          state_next = S_SCAN;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (done_next) begin
      result <= res_next;
    end
  end

  // tracking state: reset to an empty grid
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
      errs <= '0;
      vld  <= '0;
      beta <= BETA_RESET;
      for (int i = 0; i < CLASSES; i++) begin
        rl[i] <= '0;
      end
    end else begin
      errs <= errs_next;
      if (cfg_valid && cfg_ready) begin
        beta <= cfg_data;
      end
      if (grid_we) begin
        vld[waddr] <= 1'b1;
      end
      if (state == S_UPD && op == OP_ADD && a_ok && p_ok) begin
        if (LEN_W'(mx) + LEN_W'(1) > live) begin
          live <= LEN_W'(mx) + LEN_W'(1);
        end
        if (LEN_W'(cp[CLS_W-1:0]) + LEN_W'(1) > rl_a) begin
          rl[ca[CLS_W-1:0]] <= LEN_W'(cp[CLS_W-1:0]) + LEN_W'(1);
        end
      end
    end
  end

  // scan valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else begin
      rv <= rd_issue;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rd_vld <= vld[raddr];
    rr     <= sr[CLS_W-1:0];
    rp     <= sp[CLS_W-1:0];

    // accumulate the entry read last cycle
    if (rv) begin
      if (op == OP_ACC) begin
        s1 <= s1 + v;
        if (rr == rp) begin
          s0 <= s0 + v;
        end
      end else if (8'(rr) == cls && 8'(rp) == cls) begin
        s0 <= s0 + v;
      end else if (8'(rr) == cls) begin
        s1 <= s1 + v;
      end else if (8'(rp) == cls) begin
        s2 <= s2 + v;
      end
    end

    unique case (state)
      S_IDLE: begin
        op   <= cmd.operation;
        ca   <= cmd.actual_class;
        cp   <= cmd.predicted_class;
        cls  <= is_mean(cmd.operation) ? 8'd0 : cmd.predicted_class;
        b2   <= B2_W'(beta) * B2_W'(beta);
        mfin <= 1'b0;
        msum <= '0;
        sr   <= '0;
        sp   <= '0;
        s0   <= '0;
        s1   <= '0;
        s2   <= '0;
      end
      S_SCAN: begin
        // advance along the row, or drop to the next row at its end
        if (sr < live) begin
          if (sp >= rl[sr[CLS_W-1:0]]) begin
            sr <= sr + LEN_W'(1);
            sp <= '0;
          end else begin
            sp <= sp + LEN_W'(1);
          end
        end
      end
      S_CALC: begin
        mstep <= '0;
        numr  <= DEN_W'(s0);
        if (op == OP_ACC) begin
          denr <= DEN_W'(s1);
        end else if (op == OP_PREC || op == OP_MPREC) begin
          denr <= DEN_W'(s0 + s2);
        end else begin
          denr <= DEN_W'(s0 + s1);
        end
      end
      S_MUL: begin
        prod <= PROD_W'(mul_a) * PROD_W'(mul_k);
      end
      S_MACC: begin
        mstep <= mstep + 2'd1;
        unique case (mstep)
          2'd0: numr <= DEN_W'(prod);
          2'd1: numr <= numr + (DEN_W'(prod) << HALF_W);
          2'd2: denr <= numr + DEN_W'(prod);
          2'd3: denr <= denr + (DEN_W'(prod) << HALF_W);
          default: ;
        endcase
      end
      S_FBADD: begin
        denr <= denr + (DEN_W'(s2) << Q16_BITS);
      end
      S_CHECK: begin
        qv <= (denr == '0) ? '0 : Q16_ONE;
      end
      S_DIV: begin
        if (div_done && !mfin) begin
          qv <= RATIO_W'(div_quot[Q16_BITS-1:0]);
        end
      end
      S_RES: begin
        msum <= msum_sum;
        if (is_mean(op)) begin
          if ({1'b0, cls} + 9'd1 >= 9'(live)) begin
            mfin <= 1'b1;
          end else begin
            cls <= cls + 8'd1;
            sr  <= '0;
            sp  <= '0;
            s0  <= '0;
            s1  <= '0;
            s2  <= '0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/cmme_checker.sv
// Port-level checker for the confusion matrix engine, bound to the top level
`include "confusion_matrix_metrics_engine_assert.svh"

module cmme_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input cmme_pkg::item_t             cmd,
  input logic                        done,
  input cmme_pkg::result_t           result
);
  import cmme_pkg::*;

  logic acc_upd;
  logic acc_bad_add;

  assign acc_upd = start && !busy &&
                   (cmd.operation == OP_ADD || cmd.operation == OP_DEL ||
                    cmd.operation == OP_GET);
  assign acc_bad_add = start && !busy && cmd.operation == OP_ADD &&
                       {1'b0, cmd.actual_class} >= 9'(CLASSES);

  `CMME_ASSERT_NOW(a_done_idle, done, !busy)
  `CMME_ASSERT_NOW(a_ratio_range, done, result.ratio_value <= Q16_ONE)
  `CMME_ASSERT_NEXT(a_upd_busy, acc_upd, busy && !done)
  `CMME_ASSERT_NOW(a_cap_report, acc_bad_add,
                   ##2 (done && result.status_code == ST_CAPACITY && result.error_flags[0]))

endmodule

bind confusion_matrix_metrics_engine cmme_checker u_cmme_checker (.*);
